[sv/pet_pkg.sv]
// Shared types and constants for the priority extract table.
`timescale 1ns / 1ps

package pet_pkg;

	// Default number of table entries
	localparam int unsigned DefDepth = 64;

	// Operation codes carried on the opcode field
	typedef enum logic [1:0] {
		OP_APPEND   = 2'd0,
		OP_EARLIEST = 2'd1,
		OP_OLDEST   = 2'd2,
		OP_READ     = 2'd3
	} opcode_t;

	// One stored record, 52 bits
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [6:0]  age;
		logic [7:0]  location_id;
		logic [15:0] record_tag;
	} rec_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_RDWAIT,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} state_t;

endpackage

[sv/pet_pick.sv]
// Candidate selection for the extract scans (earliest date or oldest at a location).
`timescale 1ns / 1ps

module pet_pick (
	input  pet_pkg::opcode_t op,
	input  logic [7:0]       loc,
	input  pet_pkg::rec_t    cand,
	input  pet_pkg::rec_t    best,
	input  logic             found,
	output logic             take
);
	import pet_pkg::*;

	logic [20:0] cand_date;
	logic [20:0] best_date;
	logic        earlier;
	logic        older;
	logic        match;

	// Date compares as one number: year, then month, then day
	assign cand_date = {cand.year, cand.month, cand.day};
	assign best_date = {best.year, best.month, best.day};
	assign earlier   = cand_date < best_date;
	assign older     = cand.age > best.age;
	assign match     = cand.location_id == loc;

	// Strict compares keep the first entry on a tie
	always_comb begin
		if (op == OP_OLDEST) begin
			take = match && (!found || older);
		end else begin
			take = !found || earlier;
		end
	end

endmodule

[sv/priority_extract_table.sv]
// Top level: record table with append, extract-earliest, extract-oldest and read.
`timescale 1ns / 1ps
//
//  channel | handshake              | word
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid / in_ready    | opcode, year, month, day, age, location_id,
//          |                        | record_tag, position
//  out     | out_valid / out_ready  | ok, out_year, out_month, out_day, out_age,
//          |                        | out_location_id, out_record_tag
//
// One word at a time. Append and failures known up front (full, empty, read out of range)
// pass from the start state through the finish state to the output register; a read also
// waits in the read-wait state for the registered memory read. An extract scans the table
// and, if an entry was chosen, shifts the later entries down one place to close the gap;
// the single read port of the entry memory sets both passes.
// Reset clears the count and control state; the entry memory is not cleared.
// A stalled output holds the finished word and the block takes no new input word
// until that word has moved into the output register.

module priority_extract_table #(
	parameter int unsigned TABLE_DEPTH = pet_pkg::DefDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [6:0]  age,
	input  logic [7:0]  location_id,
	input  logic [15:0] record_tag,
	input  logic [5:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [11:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [6:0]  out_age,
	output logic [7:0]  out_location_id,
	output logic [15:0] out_record_tag
);
	import pet_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned PW = (CW > 6) ? CW : 6;
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

	state_t          state_q, state_d;
	opcode_t         op_q;
	rec_t            cmd_q;
	logic [5:0]      pos_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_idx_q;
	logic            found_q;
	rec_t            best_q;
	logic [IW-1:0]   best_idx_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;
	rec_t            rdata_s1;
	logic            res_ok_q;
	rec_t            res_rec_q;
	logic            out_valid_q;
	logic            out_ok_q;
	rec_t            out_rec_q;

	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            mem_we;
	logic [IW-1:0]   wa;
	rec_t            wd;
	logic            rd_more;
	logic            pos_ok;
	logic            full;
	logic            take;

	rec_t            mem [TABLE_DEPTH];

	assign rd_more = rd_idx_q < count_q;
	assign pos_ok  = PW'(pos_q) < PW'(count_q);
	assign full    = count_q == DepthC;

	pet_pick u_pick (
		.op    (op_q),
		.loc   (cmd_q.location_id),
		.cand  (rdata_s1),
		.best  (best_q),
		.found (found_q),
		.take  (take)
	);

	// Next state and memory port control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = rd_idx_q[IW-1:0];
		mem_we  = 1'b0;
		wa      = count_q[IW-1:0];
		wd      = cmd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				unique case (op_q)
					OP_APPEND: begin
						mem_we  = !full;
						state_d = ST_FINISH;
					end
					OP_READ: begin
						if (pos_ok) begin
							rd_en   = 1'b1;
							rd_addr = IW'(pos_q);
							state_d = ST_RDWAIT;
						end else begin
							state_d = ST_FINISH;
						end
					end
					OP_EARLIEST, OP_OLDEST: begin
						state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
					end
				endcase
			end
			ST_RDWAIT: begin
				state_d = ST_FINISH;
			end
			ST_SCAN: begin
				rd_en = rd_more;
				if (!rd_more && !vld_s1) state_d = found_q ? ST_SHIFT : ST_FINISH;
			end
			ST_SHIFT: begin
				// read entry k+1 ahead, write it to k in the next cycle
				rd_en  = rd_more;
				mem_we = vld_s1;
				wa     = idx_s1 - IW'(1);
				wd     = rdata_s1;
				if (!rd_more && !vld_s1) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (state_q == ST_START) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
				if (op_q == OP_APPEND && !full) count_q <= count_q + CW'(1);
			end else if (state_q == ST_SCAN && state_d == ST_SHIFT) begin
				rd_idx_q <= CW'(best_idx_q) + CW'(1);
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (state_q == ST_SCAN && vld_s1 && take) found_q <= 1'b1;
			if (state_q == ST_SHIFT && state_d == ST_FINISH) count_q <= count_q - CW'(1);
			if (state_q == ST_FINISH && state_d == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= wd;
		if (rd_en) rdata_s1 <= mem[rd_addr];
		idx_s1 <= rd_addr;
	end

	// Command, best candidate and result registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode_t'(opcode);
			cmd_q <= '{year: year, month: month, day: day, age: age,
				location_id: location_id, record_tag: record_tag};
			pos_q <= position;
		end
		if (state_q == ST_START) begin
			res_ok_q  <= (op_q == OP_APPEND) && !full;
			res_rec_q <= '0;
		end
		if (state_q == ST_RDWAIT) begin
			res_ok_q  <= 1'b1;
			res_rec_q <= rdata_s1;
		end
		if (state_q == ST_SCAN && vld_s1 && take) begin
			best_q     <= rdata_s1;
			best_idx_q <= idx_s1;
		end
		if (state_q == ST_SCAN && state_d == ST_SHIFT) begin
			res_ok_q  <= 1'b1;
			res_rec_q <= best_q;
		end
		if (state_q == ST_FINISH && state_d == ST_IDLE) begin
			out_ok_q  <= res_ok_q;
			out_rec_q <= res_rec_q;
		end
	end

	assign in_ready        = state_q == ST_IDLE;
	assign out_valid       = out_valid_q;
	assign ok              = out_ok_q;
	assign out_year        = out_rec_q.year;
	assign out_month       = out_rec_q.month;
	assign out_day         = out_rec_q.day;
	assign out_age         = out_rec_q.age;
	assign out_location_id = out_rec_q.location_id;
	assign out_record_tag  = out_rec_q.record_tag;

	// Count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC)
		else $error("entry count beyond table depth");

	// No memory traffic in flight while a new word can be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !vld_s1 && !mem_we)
		else $error("memory access while idle");

	// A successful append grows the count by one
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START && op_q == OP_APPEND && !full)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("append did not advance count");

endmodule
